// ===== design/ps2_mouse_packet_tracker_top_defines.svh =====
// Assertion macros for the PS/2 mouse packet tracker.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PMPT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmpt assertion failed");

// Antecedent implies consequent in the following cycle.
`define PMPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmpt assertion failed");

`endif

// ===== design/pmpt_pkg.sv =====
// Package for the PS/2 mouse packet tracker: widths, codes and framing states.
// Depends on nothing; used by ps2_mouse_packet_tracker_top.
`default_nettype none

package pmpt_pkg;

    localparam int POSITION_BITS_DEFAULT = 12;
    localparam int TILE_SHIFT_DEFAULT    = 4;

    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int MOVE_X_W   = 9;
    localparam int MOVE_Y_W   = 10;
    localparam int POINTER_W  = 12;
    localparam int TILE_W     = 8;
    localparam int WITHIN_W   = 4;

    localparam logic [BYTE_W-1:0] ACK_BYTE = 8'hFA;

    localparam int SYNC_BIT   = 3;
    localparam int SIGN_X_BIT = 4;
    localparam int SIGN_Y_BIT = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

    typedef enum logic [3:0] {
        ST_FIRST  = 4'b0001,
        ST_SECOND = 4'b0010,
        ST_THIRD  = 4'b0100,
        ST_WAIT   = 4'b1000
    } frame_stage_t;

endpackage

`default_nettype wire

// ===== design/ps2_mouse_packet_tracker_top.sv =====
// PS/2 mouse packet tracker: frames three-byte packets and tracks a clamped pointer.
// Depends on pmpt_pkg and ps2_mouse_packet_tracker_top_defines.svh.
//
//  Channel | Signals                              | Beat
//  --------+--------------------------------------+-------------------------------
//  in      | in_valid, in_ready, rx_byte          | one received mouse byte
//  out     | out_valid, out_ready, buttons .. etc | one decoded packet and pointer
//  cfg     | cfg_valid, cfg_ready, index, data    | one screen size register write
//
// One byte is taken every cycle while in_ready is high; the result of a packet sits
// in the output register from the cycle after its third byte is accepted.
// After reset the framer waits for the acknowledge byte; no clearing pass is needed.
// First and second bytes are taken even while a result waits to be collected.
// A third byte waits only while the output register is full and not being emptied.
// Configuration writes are always taken; cfg_ready is tied high.
`default_nettype none

module ps2_mouse_packet_tracker_top #(
    parameter int POSITION_BITS = pmpt_pkg::POSITION_BITS_DEFAULT,
    parameter int TILE_SHIFT    = pmpt_pkg::TILE_SHIFT_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [pmpt_pkg::BYTE_W-1:0]           rx_byte,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       button_left,
    output logic                                       button_right,
    output logic                                       button_middle,
    output logic signed [pmpt_pkg::MOVE_X_W-1:0]       move_x,
    output logic signed [pmpt_pkg::MOVE_Y_W-1:0]       move_y,
    output logic [pmpt_pkg::POINTER_W-1:0]             pointer_x,
    output logic [pmpt_pkg::POINTER_W-1:0]             pointer_y,
    output logic [pmpt_pkg::TILE_W-1:0]                tile_x,
    output logic [pmpt_pkg::TILE_W-1:0]                tile_y,
    output logic [pmpt_pkg::WITHIN_W-1:0]              within_x,
    output logic [pmpt_pkg::WITHIN_W-1:0]              within_y,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pmpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pmpt_pkg::CFG_W-1:0]            cfg_data
);

    import pmpt_pkg::*;

    `include "ps2_mouse_packet_tracker_top_defines.svh"

    localparam int SW    = ((POSITION_BITS > CFG_W) ? POSITION_BITS : CFG_W) + 2;
    localparam int EXT_W = (POSITION_BITS > POINTER_W) ? POSITION_BITS : POINTER_W;
    localparam logic [SW-1:0] MAX_POS =
        {{(SW-POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};
    localparam logic [POSITION_BITS-1:0] TILE_MASK =
        POSITION_BITS'((1 << TILE_SHIFT) - 1);

    function automatic logic [POSITION_BITS-1:0] clamp_axis(
        input logic [POSITION_BITS-1:0] pos,
        input logic signed [SW-1:0]     delta,
        input logic [CFG_W-1:0]         size
    );
        logic signed [SW-1:0]        sum;
        logic [SW-1:0]               limit;
        logic [POSITION_BITS-1:0]    res;
        sum = $signed({{(SW-POSITION_BITS){1'b0}}, pos}) + delta;
        if (size == '0)
        begin
            limit = '0;
        end
        else
        begin
            limit = {{(SW-CFG_W){1'b0}}, size - CFG_W'(1)};
        end
        if (limit > MAX_POS)
        begin
            limit = MAX_POS;
        end
        if (sum < 0)
        begin
            res = '0;
        end
        else if ($unsigned(sum) > limit)
        begin
            res = limit[POSITION_BITS-1:0];
        end
        else
        begin
            res = sum[POSITION_BITS-1:0];
        end
        return res;
    endfunction

    frame_stage_t               stage_reg, stage_next;
    logic [BYTE_W-1:0]          first_reg, first_next;
    logic [BYTE_W-1:0]          second_reg, second_next;
    logic [POSITION_BITS-1:0]   pos_x_reg, pos_x_next;
    logic [POSITION_BITS-1:0]   pos_y_reg, pos_y_next;
    logic [CFG_W-1:0]           width_reg, height_reg;
    logic                       out_valid_reg, out_valid_next;

    logic                       btn_l_reg, btn_r_reg, btn_m_reg;
    logic signed [MOVE_X_W-1:0] move_x_reg;
    logic signed [MOVE_Y_W-1:0] move_y_reg;
    logic [POINTER_W-1:0]       pointer_x_reg, pointer_y_reg;
    logic [TILE_W-1:0]          tile_x_reg, tile_y_reg;
    logic [WITHIN_W-1:0]        within_x_reg, within_y_reg;

    logic                       in_fire;
    logic                       packet_done;
    logic signed [MOVE_X_W-1:0] mx;
    logic signed [MOVE_Y_W-1:0] my;
    logic [MOVE_X_W-1:0]        my_raw;
    logic [EXT_W-1:0]           pos_x_ext, pos_y_ext;
    logic [POSITION_BITS-1:0]   tile_x_full, tile_y_full;
    logic [POSITION_BITS-1:0]   within_x_full, within_y_full;

    assign in_ready  = (stage_reg != ST_THIRD) || !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign packet_done = in_fire && (stage_reg == ST_THIRD);

    assign mx     = $signed({first_reg[SIGN_X_BIT], second_reg});
    assign my_raw = {first_reg[SIGN_Y_BIT], rx_byte};
    assign my     = -$signed({my_raw[MOVE_X_W-1], my_raw});

    always_comb
    begin
        stage_next  = stage_reg;
        first_next  = first_reg;
        second_next = second_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        if (in_fire)
        begin
            case (stage_reg)
                ST_FIRST:
                begin
                    if (rx_byte[SYNC_BIT])
                    begin
                        first_next = rx_byte;
                        stage_next = ST_SECOND;
                    end
                end
                ST_SECOND:
                begin
                    second_next = rx_byte;
                    stage_next  = ST_THIRD;
                end
                ST_THIRD:
                begin
                    stage_next = ST_FIRST;
                    pos_x_next = clamp_axis(pos_x_reg,
                        {{(SW-MOVE_X_W){mx[MOVE_X_W-1]}}, mx}, width_reg);
                    pos_y_next = clamp_axis(pos_y_reg,
                        {{(SW-MOVE_Y_W){my[MOVE_Y_W-1]}}, my}, height_reg);
                end
                default:
                begin
                    if (rx_byte == ACK_BYTE)
                    begin
                        stage_next = ST_FIRST;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (packet_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pos_x_ext     = EXT_W'(pos_x_next);
    assign pos_y_ext     = EXT_W'(pos_y_next);
    assign tile_x_full   = pos_x_next >> TILE_SHIFT;
    assign tile_y_full   = pos_y_next >> TILE_SHIFT;
    assign within_x_full = pos_x_next & TILE_MASK;
    assign within_y_full = pos_y_next & TILE_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ST_WAIT;
            first_reg     <= '0;
            second_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            width_reg     <= SCREEN_WIDTH_RESET;
            height_reg    <= SCREEN_HEIGHT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg     <= stage_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet_done)
        begin
            btn_l_reg     <= first_reg[0];
            btn_r_reg     <= first_reg[1];
            btn_m_reg     <= first_reg[2];
            move_x_reg    <= mx;
            move_y_reg    <= my;
            pointer_x_reg <= pos_x_ext[POINTER_W-1:0];
            pointer_y_reg <= pos_y_ext[POINTER_W-1:0];
            tile_x_reg    <= tile_x_full[TILE_W-1:0];
            tile_y_reg    <= tile_y_full[TILE_W-1:0];
            within_x_reg  <= within_x_full[WITHIN_W-1:0];
            within_y_reg  <= within_y_full[WITHIN_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign button_left   = btn_l_reg;
    assign button_right  = btn_r_reg;
    assign button_middle = btn_m_reg;
    assign move_x        = move_x_reg;
    assign move_y        = move_y_reg;
    assign pointer_x     = pointer_x_reg;
    assign pointer_y     = pointer_y_reg;
    assign tile_x        = tile_x_reg;
    assign tile_y        = tile_y_reg;
    assign within_x      = within_x_reg;
    assign within_y      = within_y_reg;

    `PMPT_ASSERT_NEXT(a_third_byte_gives_result, packet_done, out_valid_reg)
    `PMPT_ASSERT_NEXT(a_wait_holds_without_ack,
        in_fire && (stage_reg == ST_WAIT) && (rx_byte != ACK_BYTE), stage_reg == ST_WAIT)
    `PMPT_ASSERT_NEXT(a_unsynced_byte_dropped,
        in_fire && (stage_reg == ST_FIRST) && !rx_byte[SYNC_BIT], stage_reg == ST_FIRST)
    `PMPT_ASSERT_SAME(a_no_overwrite_of_waiting_result,
        packet_done && out_valid_reg, out_ready)

endmodule

`default_nettype wire
